FILE: src/smpq_pkg.sv
// smpq_pkg: shared types, constants and compare functions for the sorted min priority queue
// no dependencies
`timescale 1ns / 1ps

package smpq_pkg;

  localparam int KeyW = 32;
  localparam logic [KeyW-2:0] InfMag = 31'h7F800000;

  typedef enum logic [1:0] {
    OP_PUSH  = 2'd0,
    OP_POP   = 2'd1,
    OP_CLEAR = 2'd2,
    OP_READ  = 2'd3
  } op_t;

  typedef struct packed {
    logic push;
    logic pop;
  } cell_ctl_t;

  // order-preserving map of a float pattern; both zeros map alike
  function automatic logic [KeyW-1:0] order_key(input logic [KeyW-1:0] a);
    logic [KeyW-1:0] r;
    if (a[KeyW-2:0] == '0) begin
      r = {1'b1, {(KeyW-1){1'b0}}};
    end else if (a[KeyW-1]) begin
      r = {1'b1, {(KeyW-1){1'b0}}} - {1'b0, a[KeyW-2:0]};
    end else begin
      r = {1'b1, {(KeyW-1){1'b0}}} + a;
    end
    return r;
  endfunction

  // any compare with a nan is false
  function automatic logic ieee_less(input logic [KeyW-1:0] a, input logic [KeyW-1:0] b);
    if ((a[KeyW-2:0] > InfMag) || (b[KeyW-2:0] > InfMag)) begin
      return 1'b0;
    end
    return order_key(a) < order_key(b);
  endfunction

endpackage

FILE: src/smpq_cell.sv
// smpq_cell: one slot of the sorted chain, holds one key
// depends on smpq_pkg
`timescale 1ns / 1ps

module smpq_cell (
  input  logic                        clk,
  input  smpq_pkg::cell_ctl_t         ctl,
  input  logic                        valid,      // slot is occupied
  input  logic                        first,      // slot 0
  input  logic                        left_valid,
  input  logic                        left_less,  // left neighbor key less than new key (slot 0: not above it)
  input  logic [smpq_pkg::KeyW-1:0]   left_key,
  input  logic [smpq_pkg::KeyW-1:0]   right_key,
  input  logic [smpq_pkg::KeyW-1:0]   new_key,
  output logic                        less_out,
  output logic [smpq_pkg::KeyW-1:0]   key_out
);

  logic [smpq_pkg::KeyW-1:0] key_r, key_nxt;
  logic cmp_lt, less_here, take_new, shift_in;

  assign cmp_lt    = valid && smpq_pkg::ieee_less(key_r, new_key);
  assign less_here = first ? (valid && !smpq_pkg::ieee_less(new_key, key_r)) : cmp_lt;
  assign less_out  = less_here;
  // new key lands at first slot whose key is not below it; at slot 0 an equal key stays ahead
  assign take_new  = first ? !less_here : (left_valid && left_less && !less_here);
  assign shift_in  = first ? !less_here : !(left_valid && left_less);
  assign key_out   = key_r;

  always_comb begin
    key_nxt = key_r;
    if (ctl.push) begin
      if (take_new) begin
        key_nxt = new_key;
      end else if (shift_in && !first) begin
        key_nxt = left_key;
      end
    end else if (ctl.pop) begin
      key_nxt = right_key;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
  end

endmodule

FILE: src/sorted_min_priority_queue.sv
// sorted_min_priority_queue: top level, chain of DEPTH key cells and count
// depends on smpq_pkg, smpq_cell
// output: result of each accepted request held in an output register
// throughput: one request per cycle while in_stall is low; all cells compare and shift in parallel
// reset: entry count and output valid cleared, stored keys undefined until written
`timescale 1ns / 1ps

module sorted_min_priority_queue #(
  parameter int DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_opcode,
  input  logic [31:0] in_key,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_min_key,
  output logic        out_not_empty,
  output logic [4:0]  out_entry_count,
  output logic        out_status
);

  localparam int CntW = $clog2(DEPTH + 1);

  logic [CntW-1:0] count_r, count_nxt;
  logic            ovalid_r;
  logic [31:0]     omin_r;
  logic            onz_r, ostat_r;
  logic [4:0]      ocnt_r;
  logic            acc, full, stat;
  smpq_pkg::op_t   op;
  smpq_pkg::cell_ctl_t ctl;
  logic [31:0]     keys [DEPTH];
  logic            less [DEPTH];

  assign in_stall = ovalid_r && out_stall;
  assign acc      = in_valid && !in_stall;
  assign op       = smpq_pkg::op_t'(in_opcode);
  assign full     = (count_r == CntW'(DEPTH));

  always_comb begin
    ctl       = '0;
    count_nxt = count_r;
    stat      = 1'b0;
    unique case (op)
      smpq_pkg::OP_PUSH: begin
        if (full) begin
          stat = 1'b1;
        end else begin
          ctl.push  = acc;
          count_nxt = count_r + 1'b1;
        end
      end
      smpq_pkg::OP_POP: begin
        if (count_r != '0) begin
          ctl.pop   = acc;
          count_nxt = count_r - 1'b1;
        end
      end
      smpq_pkg::OP_CLEAR: count_nxt = '0;
      default: ;
    endcase
  end

  genvar g;
  generate
    for (g = 0; g < DEPTH; g++) begin : g_cell
      smpq_cell u_cell (
        .clk       (clk),
        .ctl       (ctl),
        .valid     (CntW'(g) < count_r),
        .first     (g == 0),
        .left_valid(g == 0 ? 1'b0 : (CntW'(g) <= count_r)),
        .left_less (g == 0 ? 1'b0 : less[(g == 0) ? 0 : g - 1]),
        .left_key  (keys[(g == 0) ? 0 : g - 1]),
        .right_key (keys[(g == DEPTH - 1) ? g : g + 1]),
        .new_key   (in_key),
        .less_out  (less[g]),
        .key_out   (keys[g])
      );
    end
  endgenerate

  // slot 0 chain link: new key goes after slot 0 when not below it
  // handled in cell via first flag; slot 1 sees slot 0 as "less" when it is not above

  logic [31:0] min_nxt;
  logic [CntW-1:0] cnt_after;
  logic take0;
  assign take0     = (count_r == '0) || smpq_pkg::ieee_less(in_key, keys[0]);
  assign cnt_after = count_nxt;

  always_comb begin
    min_nxt = keys[0];
    if (ctl.push) begin
      min_nxt = take0 ? in_key : keys[0];
    end else if (ctl.pop) begin
      min_nxt = keys[(DEPTH > 1) ? 1 : 0];
    end
    if (cnt_after == '0) begin
      min_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      ovalid_r <= 1'b0;
    end else begin
      if (acc) begin
        count_r  <= count_nxt;
        ovalid_r <= 1'b1;
      end else if (!out_stall) begin
        ovalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      omin_r  <= min_nxt;
      onz_r   <= (cnt_after != '0);
      ocnt_r  <= 5'(cnt_after);
      ostat_r <= stat;
    end
  end

  assign out_valid       = ovalid_r;
  assign out_min_key     = omin_r;
  assign out_not_empty   = onz_r;
  assign out_entry_count = ocnt_r;
  assign out_status      = ostat_r;

endmodule
